>>> sv/rdsc_pkg.sv
package rdsc_pkg;

   localparam int DIST_W  = 12;
   localparam int SPEED_W = 8;
   localparam int DIR_W   = 2;
   localparam int BTN_W   = 5;
   localparam int OBS_W   = 2;
   localparam int GAP_W   = 13;
   localparam int BEV_W   = 4;
   localparam int HZ_W    = 12;
   localparam int CSR_IDX_W = 3;
   localparam int CSR_DAT_W = 12;
   localparam int REQ_DATA_W = 24;
   localparam int RSP_DATA_W = 56;

   // drive direction
   localparam logic [DIR_W-1:0] DIR_STOP = 2'd0;
   localparam logic [DIR_W-1:0] DIR_FWD  = 2'd1;
   localparam logic [DIR_W-1:0] DIR_BACK = 2'd2;

   // nudge direction
   localparam logic [DIR_W-1:0] NUDGE_NONE = 2'd0;
   localparam logic [DIR_W-1:0] NUDGE_CCW  = 2'd1;
   localparam logic [DIR_W-1:0] NUDGE_CW   = 2'd2;

   // remote buttons
   localparam logic [BTN_W-1:0] BTN_NONE    = 5'd0;
   localparam logic [BTN_W-1:0] BTN_UP      = 5'd1;
   localparam logic [BTN_W-1:0] BTN_DOWN    = 5'd2;
   localparam logic [BTN_W-1:0] BTN_LEFT    = 5'd3;
   localparam logic [BTN_W-1:0] BTN_RIGHT   = 5'd4;
   localparam logic [BTN_W-1:0] BTN_OK      = 5'd5;
   localparam logic [BTN_W-1:0] BTN_STAR    = 5'd6;
   localparam logic [BTN_W-1:0] BTN_HASH    = 5'd7;
   localparam logic [BTN_W-1:0] BTN_DIGIT_0 = 5'd8;
   localparam logic [BTN_W-1:0] BTN_DIGIT_1 = 5'd9;
   localparam logic [BTN_W-1:0] BTN_DIGIT_9 = 5'd17;

   // obstacle events
   localparam logic [OBS_W-1:0] OBS_NONE   = 2'd0;
   localparam logic [OBS_W-1:0] OBS_STOP   = 2'd1;
   localparam logic [OBS_W-1:0] OBS_WARN   = 2'd2;
   localparam logic [OBS_W-1:0] OBS_RESUME = 2'd3;

   // button events
   localparam logic [BEV_W-1:0] BEV_NONE     = 4'd0;
   localparam logic [BEV_W-1:0] BEV_ACCEL    = 4'd1;
   localparam logic [BEV_W-1:0] BEV_SLOW     = 4'd2;
   localparam logic [BEV_W-1:0] BEV_OPP_STOP = 4'd3;
   localparam logic [BEV_W-1:0] BEV_NUDGE    = 4'd4;
   localparam logic [BEV_W-1:0] BEV_ESTOP    = 4'd5;
   localparam logic [BEV_W-1:0] BEV_BEEP     = 4'd6;
   localparam logic [BEV_W-1:0] BEV_LIGHT    = 4'd7;
   localparam logic [BEV_W-1:0] BEV_PSTOP    = 4'd8;
   localparam logic [BEV_W-1:0] BEV_PRESET   = 4'd9;
   localparam logic [BEV_W-1:0] BEV_UNKNOWN  = 4'd10;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] REG_STOP_DIST   = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_WARN_DIST   = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_RESUME_DIST = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_SPEED_STEP  = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_MIN_SPEED   = 3'd4;
   localparam logic [CSR_IDX_W-1:0] REG_MAX_SPEED   = 3'd5;
   localparam logic [CSR_IDX_W-1:0] REG_RESUME_SPD  = 3'd6;
   localparam logic [CSR_IDX_W-1:0] REG_NUDGE_SPD   = 3'd7;

   // register reset values
   localparam logic [DIST_W-1:0]  RST_STOP_DIST   = 12'd150;
   localparam logic [DIST_W-1:0]  RST_WARN_DIST   = 12'd300;
   localparam logic [DIST_W-1:0]  RST_RESUME_DIST = 12'd250;
   localparam logic [SPEED_W-1:0] RST_SPEED_STEP  = 8'd50;
   localparam logic [SPEED_W-1:0] RST_MIN_SPEED   = 8'd150;
   localparam logic [SPEED_W-1:0] RST_MAX_SPEED   = 8'd255;
   localparam logic [SPEED_W-1:0] RST_RESUME_SPD  = 8'd150;
   localparam logic [SPEED_W-1:0] RST_NUDGE_SPD   = 8'd160;

   // preset speed for digit buttons 1..9
   function automatic logic [SPEED_W-1:0] preset_speed(input logic [BTN_W-1:0] btn);
      logic [3:0]         digit;
      logic [SPEED_W-1:0] s;
      digit = 4'(btn - BTN_DIGIT_0);
      case (digit)
         4'd1:    s = 8'd50;
         4'd2:    s = 8'd75;
         4'd3:    s = 8'd100;
         4'd4:    s = 8'd130;
         4'd5:    s = 8'd155;
         4'd6:    s = 8'd180;
         4'd7:    s = 8'd200;
         4'd8:    s = 8'd228;
         4'd9:    s = 8'd255;
         default: s = 8'd0;
      endcase
      return s;
   endfunction

   // button tone
   function automatic logic [HZ_W-1:0] button_tone(input logic [BTN_W-1:0] btn);
      logic [HZ_W-1:0] hz;
      case (btn)
         BTN_UP:      hz = 12'd2500;
         BTN_DOWN:    hz = 12'd1500;
         BTN_LEFT:    hz = 12'd1800;
         BTN_RIGHT:   hz = 12'd2200;
         BTN_OK:      hz = 12'd1000;
         BTN_STAR:    hz = 12'd2000;
         BTN_DIGIT_0: hz = 12'd800;
         default: begin
            if (btn inside {[BTN_DIGIT_1:BTN_DIGIT_9]}) begin
               hz = 12'd1500 + 12'd100 * HZ_W'(btn - BTN_DIGIT_0);
            end else begin
               hz = 12'd0;
            end
         end
      endcase
      return hz;
   endfunction

endpackage

>>> sv/remote_drive_speed_controller_unit.sv
// remote drive speed controller
// req channel: one beat per control-loop pass; req_tdata carries the distance
// sample and the decoded remote button, req_tuser the distance-valid flag.
// rsp channel: exactly one beat per req beat, in order, with the new drive
// direction and speed, nudge request, obstacle event, warning gap, button
// event and button tone.
// csr channel: register writes by index, always ready; write only while the
// block is idle (all rsp beats taken).
// data path: a req beat lands in an input register, and the pass computed from
// it is loaded into the rsp register, which raises rsp_tvalid, once that
// register is empty or its beat is being taken.
// throughput: one beat per cycle while the receiver takes every rsp beat, set
// by the single update of the drive state registers that each pass needs.
// when the receiver stalls, the rsp beat holds and the input register keeps
// one more beat; req_tready drops only when both are full.
// reset clears drive state (stopped, speed 0, no obstacle stop), empties both
// stages and loads the default thresholds and speeds.
module remote_drive_speed_controller_unit (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   // distance_tenths[11:0], button[16:12], zero fill
   input  logic [rdsc_pkg::REQ_DATA_W-1:0]     req_tdata,
   // distance_ok[0]
   input  logic                                req_tuser,
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   // drive_dir[1:0], drive_speed[9:2], nudge_dir[11:10], nudge_level[19:12],
   // obstacle_event[21:20], warn_gap_ms[34:22], button_event[38:35],
   // beep_hz[50:39], zero fill
   output logic [rdsc_pkg::RSP_DATA_W-1:0]     rsp_tdata,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [rdsc_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [rdsc_pkg::CSR_DAT_W-1:0]      csr_data
);

   logic [rdsc_pkg::DIST_W-1:0]  stop_dist_ff, warn_dist_ff, resume_dist_ff;
   logic [rdsc_pkg::SPEED_W-1:0] speed_step_ff, min_speed_ff, max_speed_ff;
   logic [rdsc_pkg::SPEED_W-1:0] resume_spd_ff, nudge_spd_ff;

   logic [rdsc_pkg::DIR_W-1:0]   dir_ff, dir_in;
   logic [rdsc_pkg::SPEED_W-1:0] speed_ff, speed_in;
   logic                         obst_ff, obst_in;

   logic                         in_valid_ff;
   logic [rdsc_pkg::DIST_W-1:0]  in_dist_ff;
   logic                         in_ok_ff;
   logic [rdsc_pkg::BTN_W-1:0]   in_btn_ff;

   logic                              out_valid_ff;
   logic [rdsc_pkg::RSP_DATA_W-1:0]   out_data_ff, out_data_in;

   logic                         advance;
   logic [rdsc_pkg::DIR_W-1:0]   nudge_dir;
   logic [rdsc_pkg::SPEED_W-1:0] nudge_level;
   logic [rdsc_pkg::OBS_W-1:0]   obs_ev;
   logic [rdsc_pkg::GAP_W-1:0]   gap;
   logic [rdsc_pkg::BEV_W-1:0]   btn_ev;
   logic [rdsc_pkg::HZ_W-1:0]    hz;
   logic [rdsc_pkg::SPEED_W:0]   acc_sum;
   logic [rdsc_pkg::SPEED_W:0]   dec_floor;
   logic [rdsc_pkg::SPEED_W-1:0] preset;
   logic                         accel, decel;

   assign advance    = in_valid_ff && (!out_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || advance;
   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_data_ff;
   assign csr_ready  = 1'b1;

   // one control pass
   always_comb begin
      dir_in      = dir_ff;
      speed_in    = speed_ff;
      obst_in     = obst_ff;
      nudge_dir   = rdsc_pkg::NUDGE_NONE;
      nudge_level = '0;
      obs_ev      = rdsc_pkg::OBS_NONE;
      gap         = '0;
      btn_ev      = rdsc_pkg::BEV_NONE;
      accel       = 1'b0;
      decel       = 1'b0;
      preset      = rdsc_pkg::preset_speed(in_btn_ff);
      hz          = rdsc_pkg::button_tone(in_btn_ff);

      // obstacle check
      if (in_ok_ff && dir_ff == rdsc_pkg::DIR_FWD) begin
         if (in_dist_ff < stop_dist_ff) begin
            speed_in = '0;
            dir_in   = rdsc_pkg::DIR_STOP;
            obst_in  = 1'b1;
            obs_ev   = rdsc_pkg::OBS_STOP;
         end else if (in_dist_ff < warn_dist_ff) begin
            obs_ev = rdsc_pkg::OBS_WARN;
            gap    = {in_dist_ff - stop_dist_ff, 1'b0};
         end
      end
      if (in_ok_ff && obst_in && in_dist_ff > resume_dist_ff) begin
         obst_in  = 1'b0;
         speed_in = resume_spd_ff;
         dir_in   = rdsc_pkg::DIR_FWD;
         obs_ev   = rdsc_pkg::OBS_RESUME;
         gap      = '0;
      end

      acc_sum   = {1'b0, speed_in} + {1'b0, speed_step_ff};
      dec_floor = {1'b0, speed_step_ff} + {1'b0, min_speed_ff};

      case (in_btn_ff)
         rdsc_pkg::BTN_UP: begin
            if (dir_in == rdsc_pkg::DIR_BACK) decel = 1'b1;
            else begin
               accel  = 1'b1;
               dir_in = rdsc_pkg::DIR_FWD;
            end
         end
         rdsc_pkg::BTN_DOWN: begin
            if (dir_in == rdsc_pkg::DIR_FWD) decel = 1'b1;
            else begin
               accel  = 1'b1;
               dir_in = rdsc_pkg::DIR_BACK;
            end
         end
         rdsc_pkg::BTN_LEFT, rdsc_pkg::BTN_RIGHT: begin
            nudge_dir   = (in_btn_ff == rdsc_pkg::BTN_LEFT) ? rdsc_pkg::NUDGE_CCW
                                                            : rdsc_pkg::NUDGE_CW;
            nudge_level = nudge_spd_ff;
            btn_ev      = rdsc_pkg::BEV_NUDGE;
         end
         rdsc_pkg::BTN_OK: begin
            speed_in = '0;
            dir_in   = rdsc_pkg::DIR_STOP;
            btn_ev   = rdsc_pkg::BEV_ESTOP;
         end
         rdsc_pkg::BTN_STAR: btn_ev = rdsc_pkg::BEV_BEEP;
         rdsc_pkg::BTN_HASH: btn_ev = rdsc_pkg::BEV_LIGHT;
         rdsc_pkg::BTN_DIGIT_0: begin
            speed_in = '0;
            dir_in   = rdsc_pkg::DIR_STOP;
            btn_ev   = rdsc_pkg::BEV_PSTOP;
         end
         rdsc_pkg::BTN_NONE: btn_ev = rdsc_pkg::BEV_NONE;
         default: begin
            if (in_btn_ff inside {[rdsc_pkg::BTN_DIGIT_1:rdsc_pkg::BTN_DIGIT_9]}) begin
               speed_in = (preset < min_speed_ff) ? min_speed_ff : preset;
               if (dir_in == rdsc_pkg::DIR_STOP) dir_in = rdsc_pkg::DIR_FWD;
               btn_ev = rdsc_pkg::BEV_PRESET;
            end else begin
               btn_ev = rdsc_pkg::BEV_UNKNOWN;
            end
         end
      endcase

      if (accel) begin
         btn_ev = rdsc_pkg::BEV_ACCEL;
         if (speed_in == '0) speed_in = min_speed_ff;
         else if (acc_sum > {1'b0, max_speed_ff}) speed_in = max_speed_ff;
         else speed_in = acc_sum[rdsc_pkg::SPEED_W-1:0];
      end
      if (decel) begin
         if ({1'b0, speed_in} < dec_floor) begin
            speed_in = '0;
            dir_in   = rdsc_pkg::DIR_STOP;
            btn_ev   = rdsc_pkg::BEV_OPP_STOP;
         end else begin
            speed_in = speed_in - speed_step_ff;
            btn_ev   = rdsc_pkg::BEV_SLOW;
         end
      end

      out_data_in = {5'd0, hz, btn_ev, gap, obs_ev, nudge_level, nudge_dir,
                     speed_in, dir_in};
   end

   // register file
   always_ff @(posedge clock) begin
      if (reset) begin
         stop_dist_ff   <= rdsc_pkg::RST_STOP_DIST;
         warn_dist_ff   <= rdsc_pkg::RST_WARN_DIST;
         resume_dist_ff <= rdsc_pkg::RST_RESUME_DIST;
         speed_step_ff  <= rdsc_pkg::RST_SPEED_STEP;
         min_speed_ff   <= rdsc_pkg::RST_MIN_SPEED;
         max_speed_ff   <= rdsc_pkg::RST_MAX_SPEED;
         resume_spd_ff  <= rdsc_pkg::RST_RESUME_SPD;
         nudge_spd_ff   <= rdsc_pkg::RST_NUDGE_SPD;
      end else if (csr_valid) begin
         case (csr_index)
            rdsc_pkg::REG_STOP_DIST:   stop_dist_ff   <= csr_data;
            rdsc_pkg::REG_WARN_DIST:   warn_dist_ff   <= csr_data;
            rdsc_pkg::REG_RESUME_DIST: resume_dist_ff <= csr_data;
            rdsc_pkg::REG_SPEED_STEP:  speed_step_ff  <= csr_data[rdsc_pkg::SPEED_W-1:0];
            rdsc_pkg::REG_MIN_SPEED:   min_speed_ff   <= csr_data[rdsc_pkg::SPEED_W-1:0];
            rdsc_pkg::REG_MAX_SPEED:   max_speed_ff   <= csr_data[rdsc_pkg::SPEED_W-1:0];
            rdsc_pkg::REG_RESUME_SPD:  resume_spd_ff  <= csr_data[rdsc_pkg::SPEED_W-1:0];
            rdsc_pkg::REG_NUDGE_SPD:   nudge_spd_ff   <= csr_data[rdsc_pkg::SPEED_W-1:0];
            default: ;
         endcase
      end
   end

   // drive state and pipeline control
   always_ff @(posedge clock) begin
      if (reset) begin
         dir_ff       <= rdsc_pkg::DIR_STOP;
         speed_ff     <= '0;
         obst_ff      <= 1'b0;
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         if (req_tready) in_valid_ff <= req_tvalid;
         if (advance) begin
            dir_ff       <= dir_in;
            speed_ff     <= speed_in;
            obst_ff      <= obst_in;
            out_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   // payload
   always_ff @(posedge clock) begin
      if (req_tready && req_tvalid) begin
         in_dist_ff <= req_tdata[rdsc_pkg::DIST_W-1:0];
         in_btn_ff  <= req_tdata[rdsc_pkg::DIST_W +: rdsc_pkg::BTN_W];
         in_ok_ff   <= req_tuser;
      end
      if (advance) out_data_ff <= out_data_in;
   end

endmodule

>>> sv/rdsc_checker.sv
module rdsc_checker (
   input logic                            clock,
   input logic                            reset,
   input logic                            rsp_tvalid,
   input logic                            rsp_tready,
   input logic [rdsc_pkg::RSP_DATA_W-1:0] rsp_tdata
);

   // a stalled beat holds
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("rsp beat changed while stalled");

   // stopped drive has zero speed
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[1:0] == rdsc_pkg::DIR_STOP |-> rsp_tdata[9:2] == '0)
      else $error("stopped drive with nonzero speed");

   // nudge level only with a nudge
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[11:10] == rdsc_pkg::NUDGE_NONE |-> rsp_tdata[19:12] == '0)
      else $error("nudge level without nudge");

   // warning gap only with a warning
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[21:20] != rdsc_pkg::OBS_WARN |-> rsp_tdata[34:22] == '0)
      else $error("warning gap without warning");

   // no beat right after reset
   assert property (@(posedge clock)
      $past(reset) |-> !rsp_tvalid)
      else $error("rsp beat right after reset");

endmodule

bind remote_drive_speed_controller_unit rdsc_checker u_rdsc_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);
